// File: hw/rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, command/status structs and byte-level cipher functions.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHAIN_MODE   = 3'd5;

    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic        chain_start;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
    } aes_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       key_load;   // load round key 0 as the schedule walk's seed
        logic       key_step;   // advance the working key one round
        logic       start;      // accept item: whiten and load state
        logic       round;      // perform one middle round
        logic       last;       // perform final round and write result
        logic       pop;        // output register taken
    } aes_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_full;
    } aes_sts_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] inv_sbox(input logic [7:0] v);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 256; i++)
        begin
            if (SBOX[i] == v)
            begin
                r = 8'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of the block sits in bits 127-8i .. 120-8i.
    function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[127-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c+r) & 3))];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[127-8*(r+4*((c+r) & 3)) -: 8] = inv_sbox(get_byte(s, r + 4*c));
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2);
            a3 = get_byte(s, 4*c+3);
            t[127-32*c -: 32] = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                                 a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                                 a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                                 xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
        end
        return t;
    endfunction

    // Inverse mix as a pre-step followed by the forward mix.
    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3, u, v;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2);
            a3 = get_byte(s, 4*c+3);
            u = xt(xt(a0 ^ a2));
            v = xt(xt(a1 ^ a3));
            t[127-32*c -: 32] = {a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v};
        end
        return mix(t);
    endfunction

    function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        t = t ^ {rc, 24'h0};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // rc is the constant used when producing k from its predecessor.
    function automatic logic [127:0] key_bwd(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w3 = k[31:0] ^ k[63:32];
        w2 = k[63:32] ^ k[95:64];
        w1 = k[95:64] ^ k[127:96];
        t = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        t = t ^ {rc, 24'h0};
        w0 = k[127:96] ^ t;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [7:0] inv_xt(input logic [7:0] a);
        return a[0] ? ({1'b0, a[7:1]} ^ 8'h8d) : {1'b0, a[7:1]};
    endfunction

endpackage

// File: hw/rtl/aes_ctrl.sv
// ----------------------------------------------------------------------------
// AES-128 controller
// Sequences key preparation, rounds and output handoff.
// ----------------------------------------------------------------------------
module aes_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  logic              key_dirty,
    input  aes_pkg::aes_sts_t sts,
    output aes_pkg::aes_cmd_t cmd,
    output logic              key_ack
);
    import aes_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_KEY  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        key_ack    = 1'b0;
        in_ready   = 1'b0;
        cmd.pop    = out_valid && out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (key_dirty)
                begin
                    // Walk the schedule once to find the final round key.
                    cmd.key_load = 1'b1;
                    key_ack      = 1'b1;
                    cnt_next     = 4'(NUM_ROUNDS);
                    state_next   = ST_KEY;
                end
                else if (!sts.out_full || out_ready)
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.start  = 1'b1;
                        cnt_next   = 4'(NUM_ROUNDS - 1);
                        state_next = ST_RUN;
                    end
                end
            end
            ST_KEY:
            begin
                cmd.key_step = 1'b1;
                cnt_next     = cnt_reg - 4'd1;
                if (cnt_reg == 4'd1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == 4'd0)
                begin
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.round = 1'b1;
                    cnt_next  = cnt_reg - 4'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign out_valid = sts.out_full;

`ifndef SYNTH
    a_run_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_last_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.last |=> (state_reg == ST_IDLE))
        else $error("final round did not return to idle");
    a_start_enters_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == ST_RUN) && (cnt_reg == 4'(NUM_ROUNDS - 1)))
        else $error("round count not loaded");
`endif

endmodule

// File: hw/rtl/aes_dp.sv
// ----------------------------------------------------------------------------
// AES-128 datapath
// State register, one shared round unit, on-the-fly key schedule, chaining.
// ----------------------------------------------------------------------------
module aes_dp
(
    input  logic              clk,
    input  logic              rst_n,
    input  aes_pkg::aes_cmd_t cmd,
    output aes_pkg::aes_sts_t sts,
    input  aes_pkg::aes_in_t  in_data,
    output aes_pkg::aes_out_t out_data,
    input  logic [127:0]      key,
    input  logic [127:0]      iv,
    input  logic              decrypt_mode,
    input  logic              chain_mode
);
    import aes_pkg::*;

    logic [127:0] state_reg, state_next;
    logic [127:0] rk_reg, rk_next;      // working round key
    logic [127:0] last_key_reg;         // round key 10, found after a key write
    logic [7:0]   rc_reg, rc_next;
    logic [127:0] chain_reg, chain_next;
    logic [127:0] prev_reg;             // chaining value for this decrypt
    logic [127:0] out_reg;
    logic         full_reg;
    logic         dec_reg, cbc_reg;
    logic [127:0] din, chain_use, kx, round_out, res;

    always_comb
    begin
        din       = {in_data.data_high, in_data.data_low};
        chain_use = in_data.chain_start ? iv : chain_reg;
        rk_next   = rk_reg;
        rc_next   = rc_reg;
        state_next = state_reg;
        chain_next = chain_reg;
        round_out = '0;
        res       = '0;
        kx        = '0;

        if (cmd.key_load)
        begin
            rk_next = key;
            rc_next = 8'h01;
        end
        else if (cmd.key_step)
        begin
            rk_next = key_fwd(rk_reg, rc_reg);
            rc_next = xt(rc_reg);
        end
        else if (cmd.start)
        begin
            if (!decrypt_mode)
            begin
                kx = key_fwd(key, 8'h01);
                state_next = (chain_mode ? din ^ chain_use : din) ^ key;
                rk_next = kx;
                rc_next = 8'h02;
            end
            else
            begin
                // Step back from round key 10 to round key 9 (rcon 0x36).
                kx = key_bwd(last_key_reg, 8'h36);
                state_next = inv_sub_shift(din ^ last_key_reg);
                rk_next = kx;
                rc_next = 8'h1b;
            end
            if (in_data.chain_start)
            begin
                chain_next = iv;
            end
            if (decrypt_mode && chain_mode)
            begin
                chain_next = din;
            end
        end
        else if (cmd.round || cmd.last)
        begin
            if (!dec_reg)
            begin
                if (cmd.round)
                begin
                    round_out = mix(sub_shift(state_reg)) ^ rk_reg;
                    rk_next   = key_fwd(rk_reg, rc_reg);
                    rc_next   = xt(rc_reg);
                end
                else
                begin
                    round_out = sub_shift(state_reg) ^ rk_reg;
                end
            end
            else
            begin
                if (cmd.round)
                begin
                    round_out = inv_sub_shift(inv_mix(state_reg ^ rk_reg));
                    rk_next   = key_bwd(rk_reg, rc_reg);
                    rc_next   = inv_xt(rc_reg);
                end
                else
                begin
                    round_out = state_reg ^ rk_reg;
                end
            end
            state_next = round_out;
            if (cmd.last)
            begin
                res = (dec_reg && cbc_reg) ? round_out ^ prev_reg : round_out;
                if (!dec_reg && cbc_reg)
                begin
                    chain_next = round_out;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            chain_reg <= chain_next;
            if (cmd.last)
            begin
                full_reg <= 1'b1;
            end
            else if (cmd.pop)
            begin
                full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        rk_reg    <= rk_next;
        rc_reg    <= rc_next;
        if (cmd.key_step)
        begin
            last_key_reg <= rk_next;
        end
        if (cmd.start)
        begin
            dec_reg  <= decrypt_mode;
            cbc_reg  <= chain_mode;
            prev_reg <= chain_use;
        end
        if (cmd.last)
        begin
            out_reg <= res;
        end
    end

    assign sts.out_full     = full_reg;
    assign out_data.out_high = out_reg[127:64];
    assign out_data.out_low  = out_reg[63:0];

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.last && full_reg) |-> cmd.pop)
        else $error("result overwritten before it was taken");
    a_ecb_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.last && !cbc_reg) |=> $stable(chain_reg))
        else $error("chain value changed in ECB");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.key_load, cmd.key_step, cmd.start, cmd.round, cmd.last}))
        else $error("conflicting datapath commands");
`endif

endmodule

// File: hw/rtl/aes128_ecb_cbc_cipher.sv
// ----------------------------------------------------------------------------
// AES-128 ECB/CBC cipher
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one 128-bit word plus a chain_start flag;
//   out_valid/out_ready return the transformed word. Settings must be
//   written through cfg_we/cfg_index/cfg_data only while the block is idle;
//   the user sees to this, as the block itself does not enforce it.
// The initial key addition happens at the accepting edge, then nine middle
//   rounds and the final round follow, one per cycle, through the single
//   shared round unit; the final round writes the result word. The next
//   word is taken only once the block is back in idle. Round keys are
//   derived on the fly beside the rounds.
// A key write triggers a walk of the key schedule (one load and ten steps)
//   to find the last round key for decryption; no word is taken during that
//   walk.
// Reset clears the chaining value, the settings and the control state and
//   starts that key walk for the all-zero key.
// One output register holds the result; while the receiver stalls, the
//   next word is taken only once that register is being emptied.
// ----------------------------------------------------------------------------
module aes128_ecb_cbc_cipher
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  aes_pkg::aes_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output aes_pkg::aes_out_t out_data,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data
);
    import aes_pkg::*;

    logic [63:0] key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic        dec_mode_reg, chain_mode_reg, key_dirty_reg;
    logic        key_ack;
    aes_cmd_t    cmd;
    aes_sts_t    sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg   <= '0;
            key_low_reg    <= '0;
            iv_high_reg    <= '0;
            iv_low_reg     <= '0;
            dec_mode_reg   <= 1'b0;
            chain_mode_reg <= 1'b0;
            key_dirty_reg  <= 1'b1;
        end
        else
        begin
            if (key_ack)
            begin
                key_dirty_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KEY_HIGH:
                    begin
                        key_high_reg  <= cfg_data;
                        key_dirty_reg <= 1'b1;
                    end
                    REG_KEY_LOW:
                    begin
                        key_low_reg   <= cfg_data;
                        key_dirty_reg <= 1'b1;
                    end
                    REG_IV_HIGH:      iv_high_reg    <= cfg_data;
                    REG_IV_LOW:       iv_low_reg     <= cfg_data;
                    REG_DECRYPT_MODE: dec_mode_reg   <= cfg_data[0];
                    REG_CHAIN_MODE:   chain_mode_reg <= cfg_data[0];
                    default:          ;
                endcase
            end
        end
    end

    aes_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .key_dirty (key_dirty_reg),
        .sts       (sts),
        .cmd       (cmd),
        .key_ack   (key_ack)
    );

    aes_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_data      (in_data),
        .out_data     (out_data),
        .key          ({key_high_reg, key_low_reg}),
        .iv           ({iv_high_reg, iv_low_reg}),
        .decrypt_mode (dec_mode_reg),
        .chain_mode   (chain_mode_reg)
    );

endmodule

// File: tb/sv/aes_block_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 ECB/CBC result checker
// Follows the settings port, the input and the output channel of the cipher,
// computes each transformed block with its own AES-128 model and chaining
// value, and compares every returned word with the oldest predicted block.
// ----------------------------------------------------------------------------
module aes_block_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  aes_pkg::aes_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  aes_pkg::aes_out_t out_data,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    output int                fail_count,
    output int                pending,
    output int                words_checked
);
    import aes_pkg::*;

    logic [7:0]   inv_tab [256];
    logic [127:0] round_keys [0:10];
    logic [127:0] cipher_key;
    logic [127:0] init_vector;
    logic [127:0] chain_value;
    logic         decrypt_on;
    logic         cbc_on;
    aes_out_t     block_q [$];

    initial
    begin
        for (int i = 0; i < 256; i++)
        begin
            inv_tab[SBOX[i]] = 8'(i);
        end
    end

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                p = p ^ a;
            end
            a = gf_double(a);
        end
        return p;
    endfunction

    // Byte i of a block sits in bits 127-8i down to 120-8i.
    function automatic logic [7:0] blk_byte(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    function automatic logic [127:0] fwd_sub_rows(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[127-8*(r+4*c) -: 8] = SBOX[blk_byte(s, r + 4*((c+r) & 3))];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_sub_rows(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[127-8*(r+4*((c+r) & 3)) -: 8] = inv_tab[blk_byte(s, r + 4*c)];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0 = blk_byte(s, 4*c);
            a1 = blk_byte(s, 4*c+1);
            a2 = blk_byte(s, 4*c+2);
            a3 = blk_byte(s, 4*c+3);
            if (!inv)
            begin
                t[127-32*c -: 32] = {gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3,
                                     a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3,
                                     a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03),
                                     gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02)};
            end
            else
            begin
                t[127-32*c -: 32] = {
                    gf_mul(a0, 8'h0e) ^ gf_mul(a1, 8'h0b) ^ gf_mul(a2, 8'h0d) ^ gf_mul(a3, 8'h09),
                    gf_mul(a0, 8'h09) ^ gf_mul(a1, 8'h0e) ^ gf_mul(a2, 8'h0b) ^ gf_mul(a3, 8'h0d),
                    gf_mul(a0, 8'h0d) ^ gf_mul(a1, 8'h09) ^ gf_mul(a2, 8'h0e) ^ gf_mul(a3, 8'h0b),
                    gf_mul(a0, 8'h0b) ^ gf_mul(a1, 8'h0d) ^ gf_mul(a2, 8'h09) ^ gf_mul(a3, 8'h0e)};
            end
        end
        return t;
    endfunction

    task automatic expand_schedule();
        logic [31:0] w [0:43];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        {w[0], w[1], w[2], w[3]} = cipher_key;
        for (int i = 4; i < 44; i++)
        begin
            t = w[i-1];
            if ((i % 4) == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
                t = t ^ {rc, 24'h0};
                rc = gf_double(rc);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r <= 10; r++)
        begin
            round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
        end
    endtask

    function automatic logic [127:0] encrypt_block(input logic [127:0] s);
        s = s ^ round_keys[0];
        for (int r = 1; r < 10; r++)
        begin
            s = mix_columns(fwd_sub_rows(s), 1'b0) ^ round_keys[r];
        end
        return fwd_sub_rows(s) ^ round_keys[10];
    endfunction

    function automatic logic [127:0] decrypt_block(input logic [127:0] s);
        s = inv_sub_rows(s ^ round_keys[10]);
        for (int r = 9; r > 0; r--)
        begin
            s = inv_sub_rows(mix_columns(s ^ round_keys[r], 1'b1));
        end
        return s ^ round_keys[0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [127:0] word_in;
        logic [127:0] res;
        aes_out_t     want;
        if (!rst_n)
        begin
            cipher_key    = '0;
            init_vector   = '0;
            chain_value   = '0;
            decrypt_on    = 1'b0;
            cbc_on        = 1'b0;
            fail_count    = 0;
            words_checked = 0;
            block_q.delete();
            expand_schedule();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KEY_HIGH:
                    begin
                        cipher_key[127:64] = cfg_data;
                        expand_schedule();
                    end
                    REG_KEY_LOW:
                    begin
                        cipher_key[63:0] = cfg_data;
                        expand_schedule();
                    end
                    REG_IV_HIGH:      init_vector[127:64] = cfg_data;
                    REG_IV_LOW:       init_vector[63:0] = cfg_data;
                    REG_DECRYPT_MODE: decrypt_on = cfg_data[0];
                    REG_CHAIN_MODE:   cbc_on = cfg_data[0];
                    default:          ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                word_in = {in_data.data_high, in_data.data_low};
                if (in_data.chain_start)
                begin
                    chain_value = init_vector;
                end
                if (!decrypt_on)
                begin
                    res = encrypt_block(cbc_on ? (word_in ^ chain_value) : word_in);
                    if (cbc_on)
                    begin
                        chain_value = res;
                    end
                end
                else
                begin
                    res = decrypt_block(word_in);
                    if (cbc_on)
                    begin
                        res = res ^ chain_value;
                        chain_value = word_in;
                    end
                end
                block_q.push_back(aes_out_t'(res));
            end
            if (out_valid && out_ready)
            begin
                if (block_q.size() == 0)
                begin
                    $error("unexpected output word %h", out_data);
                    fail_count++;
                end
                else
                begin
                    want = block_q.pop_front();
                    if (out_data.out_high !== want.out_high)
                    begin
                        $error("out_high mismatch: expected %h, actual %h",
                               want.out_high, out_data.out_high);
                        fail_count++;
                    end
                    if (out_data.out_low !== want.out_low)
                    begin
                        $error("out_low mismatch: expected %h, actual %h",
                               want.out_low, out_data.out_low);
                        fail_count++;
                    end
                    words_checked++;
                end
            end
        end
        pending = block_q.size();
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 ECB/CBC cipher testbench
// Drives known-answer and random words through the cipher under many key,
// IV and mode settings, with random gaps and stalls on both channels and one
// long output stall, and leaves all checking to the block checker.
// ----------------------------------------------------------------------------
module tb;
    import aes_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam logic [2:0] REG_TOP    = 3'd7;
    localparam int         CYCLE_LIMIT = 800000;
    localparam int         DRAIN_CYCLES = 30;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    aes_in_t     in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    aes_out_t    out_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_KEY_HIGH;
    logic [63:0] cfg_data = '0;

    int  fail_count;
    int  pending;
    int  words_checked;
    int  cycle_count = 0;
    int  settings_used = 0;
    bit  sender_busy_only = 1'b0;
    bit  hold_request = 1'b0;
    bit  hold_done = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    aes128_ecb_cbc_cipher i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    aes_block_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    function automatic int gap_length();
        int p;
        p = $urandom_range(99);
        if (p < 65)
        begin
            return 0;
        end
        else if (p < 93)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    // The receiver stalls at random; once asked, it holds off long enough for
    // the cipher to fill up and stop taking words.
    always @(posedge clk)
    begin
        int hold_cycles;
        if (hold_request && !hold_done)
        begin
            hold_cycles = 0;
            out_ready <= 1'b0;
            while (hold_cycles < 300)
            begin
                @(posedge clk);
                hold_cycles++;
            end
            hold_done = 1'b1;
            out_ready <= 1'b1;
        end
        else if (sender_busy_only)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            out_ready <= (gap_length() == 0);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_word(input logic [63:0] hi, input logic [63:0] lo, input logic start);
        int  gap;
        logic rdy;
        gap = sender_busy_only ? 0 : gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{data_high: hi, data_low: lo, chain_start: start};
        do
        begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end
        while (!rdy);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        // A key write starts a schedule walk inside the block; let it settle.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write enable stays high across back-to-back writes; the caller drops it
    // after the last one.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic load_setting(input logic [127:0] key, input logic [127:0] iv,
                                input logic dec, input logic cbc);
        wait_idle();
        write_reg(REG_KEY_HIGH, key[127:64]);
        write_reg(REG_KEY_LOW, key[63:0]);
        write_reg(REG_IV_HIGH, iv[127:64]);
        write_reg(REG_IV_LOW, iv[63:0]);
        write_reg(REG_DECRYPT_MODE, {63'h0, dec});
        write_reg(REG_CHAIN_MODE, {63'h0, cbc});
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    task automatic set_mode(input logic dec, input logic cbc);
        wait_idle();
        write_reg(REG_DECRYPT_MODE, {63'h0, dec});
        write_reg(REG_CHAIN_MODE, {63'h0, cbc});
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    initial
    begin
        logic [127:0] key;
        logic [127:0] iv;
        int           sent;
        int           msg_len;
        sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero key, ECB encryption.
        send_word('0, '0, 1'b0);
        send_word('1, '1, 1'b1);

        // Known-answer key, all four mode combinations.
        key = 128'h000102030405060708090a0b0c0d0e0f;
        iv  = 128'hfedcba98765432100123456789abcdef;
        load_setting(key, iv, 1'b0, 1'b0);
        send_word(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
        send_word(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
        set_mode(1'b1, 1'b0);
        send_word(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0);
        send_word('1, '0, 1'b0);
        set_mode(1'b0, 1'b1);
        send_word(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
        send_word('0, '1, 1'b0);
        send_word('1, '1, 1'b0);
        set_mode(1'b1, 1'b1);
        send_word(64'h0123456789abcdef, 64'h0f1e2d3c4b5a6978, 1'b1);
        send_word('0, '0, 1'b0);
        // A mode change in the middle of a message keeps the chaining value.
        set_mode(1'b0, 1'b1);
        send_word('1, '0, 1'b0);
        set_mode(1'b0, 1'b0);
        send_word(rand64(), rand64(), 1'b0);
        set_mode(1'b1, 1'b1);
        send_word(rand64(), rand64(), 1'b0);

        // Out-of-range indexes must leave every setting alone.
        wait_idle();
        write_reg(REG_UNUSED, '1);
        write_reg(REG_TOP, '1);
        cfg_we <= 1'b0;
        send_word(rand64(), rand64(), 1'b1);

        // Extreme keys and IVs.
        load_setting('1, '1, 1'b0, 1'b1);
        send_word('0, '0, 1'b1);
        send_word('1, '1, 1'b0);
        load_setting('1, '1, 1'b1, 1'b1);
        send_word('0, '0, 1'b1);
        send_word('1, '1, 1'b0);
        sent = 19;

        for (int ph = 0; ph < 20; ph++)
        begin
            case ($urandom_range(9))
                0:       key = '0;
                1:       key = '1;
                default: key = {rand64(), rand64()};
            endcase
            iv = ($urandom_range(5) == 0) ? {128{ph[0]}} : {rand64(), rand64()};
            load_setting(key, iv, 1'($urandom), 1'($urandom));
            sender_busy_only = (ph % 5 == 3);
            if (ph == 7)
            begin
                sender_busy_only = 1'b1;
                hold_request = 1'b1;
            end
            for (int n = 0; n < 39; n += msg_len)
            begin
                msg_len = $urandom_range(8, 1);
                if ($urandom_range(9) == 0)
                begin
                    // Mode flip between messages and, now and then, inside one.
                    set_mode(1'($urandom), 1'($urandom));
                end
                for (int k = 0; k < msg_len; k++)
                begin
                    // Mostly proper messages; a few stray start flags as noise.
                    send_word(rand64(), rand64(),
                              (k == 0) ? ($urandom_range(7) != 0)
                                       : ($urandom_range(15) == 0));
                    sent++;
                end
            end
            sender_busy_only = 1'b0;
        end

        wait_idle();
        $display("Ran %0d words through %0d key/IV/mode settings, ECB and CBC both ways,",
                 sent, settings_used);
        $display("with random stalls on both sides; %0d output words checked.",
                 words_checked);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
